>>> sv/sjds_pkg.sv
// Shared types and constants for the scan job duty-cycle selector.
// No dependencies; used by sjds_div and scan_job_duty_cycle_selector.
package sjds_pkg;

  // Field widths
  localparam int FIELD_W = 15;   // window / interval
  localparam int TIME_W  = 16;   // lifetime and tick in deciseconds
  localparam int DUTY_W  = 22;   // floor(window*100/interval), window < 2**15

  // Operation codes
  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_TICK   = 2'd2;

  // Job types for add
  localparam logic [1:0] JOB_HIGH    = 2'd0;
  localparam logic [1:0] JOB_LOW     = 2'd1;
  localparam logic [1:0] JOB_CUSTOM  = 2'd2;
  localparam logic [1:0] JOB_ILLEGAL = 2'd3;

  // Slot states
  localparam logic [1:0] ST_FREE     = 2'd0;
  localparam logic [1:0] ST_ACTIVE   = 2'd1;
  localparam logic [1:0] ST_INACTIVE = 2'd2;

  // Result status codes
  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_BAD_STATE = 3'd1;
  localparam logic [2:0] STAT_BAD_TYPE  = 3'd2;
  localparam logic [2:0] STAT_FULL      = 3'd3;
  localparam logic [2:0] STAT_BAD_PARAM = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] REG_HIGH_INTERVAL = 2'd0;
  localparam logic [1:0] REG_HIGH_WINDOW   = 2'd1;
  localparam logic [1:0] REG_LOW_INTERVAL  = 2'd2;
  localparam logic [1:0] REG_LOW_WINDOW    = 2'd3;

  // Configuration reset values
  localparam logic [FIELD_W-1:0] HIGH_INTERVAL_RST = 15'd160;
  localparam logic [FIELD_W-1:0] HIGH_WINDOW_RST   = 15'd160;
  localparam logic [FIELD_W-1:0] LOW_INTERVAL_RST  = 15'd1600;
  localparam logic [FIELD_W-1:0] LOW_WINDOW_RST    = 15'd16;

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> sv/sjds_div.sv
// Iterative duty-cycle divider: floor(window*100/interval), one quotient bit per cycle.
// Depends on sjds_pkg; instantiated by scan_job_duty_cycle_selector.
module sjds_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [sjds_pkg::FIELD_W-1:0]  window,
  input  logic [sjds_pkg::FIELD_W-1:0]  interval,
  output sjds_pkg::div_stat_t           stat,
  output logic [sjds_pkg::DUTY_W-1:0]   duty
);

  localparam int DW    = sjds_pkg::DUTY_W;
  localparam int FW    = sjds_pkg::FIELD_W;
  localparam int CNT_W = $clog2(DW + 1);

  logic             running;
  logic [CNT_W-1:0] cnt;
  logic [DW-1:0]    num;
  logic [DW-1:0]    quo;
  logic [FW-1:0]    rem;
  logic [FW-1:0]    den;

  logic [DW-1:0]    scaled;
  logic [FW:0]      rem_sh;
  logic [FW:0]      diff;
  logic             ge;
  logic [FW-1:0]    rem_next;

  // window*100 as window*64 + window*32 + window*4
  assign scaled = DW'({window, 6'b0}) + DW'({window, 5'b0}) + DW'({window, 2'b0});

  // One restoring step: shift in the next dividend bit, subtract when it fits
  always_comb begin
    rem_sh   = {rem, num[DW-1]};
    diff     = rem_sh - {1'b0, den};
    ge       = (rem_sh >= {1'b0, den});
    rem_next = ge ? diff[FW-1:0] : rem_sh[FW-1:0];
  end

  // Run flag
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
    end else if (start) begin
      running <= 1'b1;
    end else if (running && cnt == '0) begin
      running <= 1'b0;
    end
  end

  // Datapath; a zero interval skips the steps and leaves a zero quotient
  always_ff @(posedge clk) begin
    if (start) begin
      num <= scaled;
      quo <= '0;
      rem <= '0;
      den <= interval;
      cnt <= (interval == '0) ? '0 : CNT_W'(DW);
    end else if (running && cnt != '0) begin
      num <= {num[DW-2:0], 1'b0};
      quo <= {quo[DW-2:0], ge};
      rem <= rem_next;
      cnt <= cnt - 1'b1;
    end
  end

  assign stat.busy = running;
  assign stat.done = running && (cnt == '0);
  assign duty      = quo;

endmodule

>>> sv/scan_job_duty_cycle_selector.sv
// Scan job duty-cycle selector: slot table, tick walk and reselection sequencer.
// Depends on sjds_pkg and sjds_div.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+--------------------------------------------
//   in      | to block  | in_valid / in_stall  | kind job_type job_state custom_interval
//           |           |                      | custom_window timed_mode time_ds slot
//   out     | from block| out_valid / out_stall| status granted_slot params_changed
//           |           |                      | scan_window scan_interval
//   cfg     | to block  | cfg_valid / cfg_ready| cfg_index cfg_data
//
// A successful add computes the new job's duty in the divider, then runs a reselection
// scan; a remove runs one scan; a failed add or a no-op completes without either; a
// tick walks the slots and runs one reselection scan for every job that times out.
// The duty of each job is computed once at add and kept with the slot, so a
// reselection is a compare scan over the slots, one slot per cycle.
// Reset is synchronous: all slots free, scan parameters zero, registers at defaults.
// The input is stalled from the beat until the result is in the output register;
// a result held by out_stall blocks only the completion of the following item.
module scan_job_duty_cycle_selector #(
  parameter int JOB_SLOTS = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    kind,
  input  logic [1:0]                    job_type,
  input  logic [1:0]                    job_state,
  input  logic [sjds_pkg::FIELD_W-1:0]  custom_interval,
  input  logic [sjds_pkg::FIELD_W-1:0]  custom_window,
  input  logic                          timed_mode,
  input  logic [sjds_pkg::TIME_W-1:0]   time_ds,
  input  logic [1:0]                    slot,
  // output channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    status,
  output logic [1:0]                    granted_slot,
  output logic                          params_changed,
  output logic [sjds_pkg::FIELD_W-1:0]  scan_window,
  output logic [sjds_pkg::FIELD_W-1:0]  scan_interval,
  // configuration channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [sjds_pkg::FIELD_W-1:0]  cfg_data
);

  localparam int FW     = sjds_pkg::FIELD_W;
  localparam int TW     = sjds_pkg::TIME_W;
  localparam int DW     = sjds_pkg::DUTY_W;
  localparam int SLOT_W = (JOB_SLOTS > 1) ? $clog2(JOB_SLOTS) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(JOB_SLOTS - 1);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_CHECK   = 7'b0000010,
    S_DIV     = 7'b0000100,
    S_SCAN    = 7'b0001000,
    S_RESOLVE = 7'b0010000,
    S_TICK    = 7'b0100000,
    S_DONE    = 7'b1000000
  } state_t;

  state_t state, state_next;

  // Configuration registers
  logic [FW-1:0] high_interval, high_window, low_interval, low_window;

  // Captured input beat
  logic [1:0]    op_kind, op_type, op_jst, op_slot;
  logic [FW-1:0] op_cint, op_cwin;
  logic          op_timed;
  logic [TW-1:0] op_tds;

  // Slot table
  logic [1:0]    slot_state     [JOB_SLOTS];
  logic          slot_timed     [JOB_SLOTS];
  logic [TW-1:0] slot_time_left [JOB_SLOTS];
  logic [FW-1:0] slot_window    [JOB_SLOTS];
  logic [FW-1:0] slot_interval  [JOB_SLOTS];
  logic [DW-1:0] slot_duty      [JOB_SLOTS];

  // Current scan parameters and their duty
  logic [FW-1:0] active_window, active_interval;
  logic [DW-1:0] active_duty;

  // Scan and tick walk
  logic [SLOT_W-1:0] scan_idx, pick, tidx;
  logic [DW-1:0]     best;
  logic              found;

  // Result under construction
  logic [2:0] status_r;
  logic [1:0] granted_r;
  logic       changed_r;

  // Add decode
  logic              free_found;
  logic [SLOT_W-1:0] free_idx;
  logic [FW-1:0]     add_w, add_iv;
  logic              add_tm;
  logic [2:0]        add_status;
  logic              div_start;

  sjds_pkg::div_stat_t div_stat;
  logic [DW-1:0]       div_duty;

  logic in_beat, out_load, scan_hit, tick_live, tick_expire, remove_hit;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_beat   = in_valid && !in_stall;
  assign out_load  = (state == S_DONE) && (!out_valid || !out_stall);

  // Find the lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = JOB_SLOTS - 1; i >= 0; i--) begin
      if (slot_state[i] == sjds_pkg::ST_FREE) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  // Pick the new job's parameters and check the add
  always_comb begin
    case (op_type)
      sjds_pkg::JOB_HIGH: begin
        add_w  = high_window;
        add_iv = high_interval;
        add_tm = 1'b0;
      end
      sjds_pkg::JOB_LOW: begin
        add_w  = low_window;
        add_iv = low_interval;
        add_tm = 1'b0;
      end
      default: begin
        add_w  = op_cwin;
        add_iv = op_cint;
        add_tm = op_timed;
      end
    endcase

    if (op_jst == sjds_pkg::ST_FREE) begin
      add_status = sjds_pkg::STAT_BAD_STATE;
    end else if (op_type == sjds_pkg::JOB_ILLEGAL) begin
      add_status = sjds_pkg::STAT_BAD_TYPE;
    end else if (op_type == sjds_pkg::JOB_CUSTOM &&
                 (op_cint == '0 || op_cwin > op_cint)) begin
      add_status = sjds_pkg::STAT_BAD_PARAM;
    end else if (!free_found) begin
      add_status = sjds_pkg::STAT_FULL;
    end else begin
      add_status = sjds_pkg::STAT_OK;
    end
  end

  assign div_start = (state == S_CHECK) && (op_kind == sjds_pkg::KIND_ADD) &&
                     (add_status == sjds_pkg::STAT_OK);

  assign remove_hit = (32'(op_slot) < JOB_SLOTS);

  // Per-cycle scan compare and tick test
  assign scan_hit    = (slot_state[scan_idx] == sjds_pkg::ST_ACTIVE) &&
                       (slot_duty[scan_idx] > best);
  assign tick_live   = (slot_state[tidx] == sjds_pkg::ST_ACTIVE) && slot_timed[tidx];
  assign tick_expire = tick_live && (slot_time_left[tidx] <= op_tds);

  sjds_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .window   (add_w),
    .interval (add_iv),
    .stat     (div_stat),
    .duty     (div_duty)
  );

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_CHECK;
      end
      S_CHECK: begin
        unique case (op_kind)
          sjds_pkg::KIND_ADD:    state_next = div_start ? S_DIV : S_DONE;
          sjds_pkg::KIND_REMOVE: state_next = S_SCAN;
          sjds_pkg::KIND_TICK:   state_next = S_TICK;
          default:               state_next = S_DONE;
        endcase
      end
      S_DIV: begin
        if (div_stat.done) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (scan_idx == LAST_SLOT) state_next = S_RESOLVE;
      end
      S_RESOLVE: begin
        if (op_kind == sjds_pkg::KIND_TICK && tidx != LAST_SLOT) begin
          state_next = S_TICK;
        end else begin
          state_next = S_DONE;
        end
      end
      S_TICK: begin
        if (tick_expire) begin
          state_next = S_SCAN;
        end else if (tidx == LAST_SLOT) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      out_valid       <= 1'b0;
      high_interval   <= sjds_pkg::HIGH_INTERVAL_RST;
      high_window     <= sjds_pkg::HIGH_WINDOW_RST;
      low_interval    <= sjds_pkg::LOW_INTERVAL_RST;
      low_window      <= sjds_pkg::LOW_WINDOW_RST;
      active_window   <= '0;
      active_interval <= '0;
      active_duty     <= '0;
      scan_idx        <= '0;
      best            <= '0;
      found           <= 1'b0;
      tidx            <= '0;
      status_r        <= sjds_pkg::STAT_OK;
      granted_r       <= '0;
      changed_r       <= 1'b0;
      for (int i = 0; i < JOB_SLOTS; i++) begin
        slot_state[i] <= sjds_pkg::ST_FREE;
      end
    end else begin
      state <= state_next;

      // Register writes
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          sjds_pkg::REG_HIGH_INTERVAL: high_interval <= cfg_data;
          sjds_pkg::REG_HIGH_WINDOW:   high_window   <= cfg_data;
          sjds_pkg::REG_LOW_INTERVAL:  low_interval  <= cfg_data;
          sjds_pkg::REG_LOW_WINDOW:    low_window    <= cfg_data;
          default: ;
        endcase
      end

      // Output register: load on completion, drop once the beat is taken
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      // Clear the result on a new beat
      if (in_beat) begin
        status_r  <= sjds_pkg::STAT_OK;
        granted_r <= '0;
        changed_r <= 1'b0;
      end

      // Scan: track the first highest duty among active slots
      if (state == S_SCAN) begin
        scan_idx <= (scan_idx == LAST_SLOT) ? '0 : scan_idx + 1'b1;
        if (scan_hit) begin
          best  <= slot_duty[scan_idx];
          found <= 1'b1;
        end
      end else begin
        scan_idx <= '0;
        best     <= '0;
        found    <= 1'b0;
      end

      unique case (state)
        S_CHECK: begin
          tidx <= '0;
          if (op_kind == sjds_pkg::KIND_ADD) status_r <= add_status;
          if (op_kind == sjds_pkg::KIND_REMOVE && remove_hit) begin
            slot_state[SLOT_W'(op_slot)] <= sjds_pkg::ST_FREE;
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            slot_state[free_idx] <= (op_jst == sjds_pkg::ST_ACTIVE) ?
                                    sjds_pkg::ST_ACTIVE : sjds_pkg::ST_INACTIVE;
            granted_r <= 2'(free_idx);
          end
        end
        S_RESOLVE: begin
          // Replace the parameters only when the best duty differs
          if (best != active_duty) begin
            active_duty     <= best;
            active_window   <= found ? slot_window[pick] : '0;
            active_interval <= found ? slot_interval[pick] : '0;
            changed_r       <= 1'b1;
          end
          tidx <= tidx + 1'b1;
        end
        S_TICK: begin
          if (tick_expire) begin
            slot_state[tidx] <= sjds_pkg::ST_FREE;
          end else begin
            tidx <= tidx + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_beat) begin
      op_kind  <= kind;
      op_type  <= job_type;
      op_jst   <= job_state;
      op_cint  <= custom_interval;
      op_cwin  <= custom_window;
      op_timed <= timed_mode;
      op_tds   <= time_ds;
      op_slot  <= slot;
    end

    // Fill the granted slot once its duty is known
    if (state == S_DIV && div_stat.done) begin
      slot_window[free_idx]    <= add_w;
      slot_interval[free_idx]  <= add_iv;
      slot_duty[free_idx]      <= div_duty;
      slot_timed[free_idx]     <= add_tm;
      slot_time_left[free_idx] <= op_tds;
    end

    // Count down a live timed job that survives this tick
    if (state == S_TICK && tick_live && !tick_expire) begin
      slot_time_left[tidx] <= slot_time_left[tidx] - op_tds;
    end

    if (state == S_SCAN && scan_hit) begin
      pick <= scan_idx;
    end

    if (out_load) begin
      status         <= status_r;
      granted_slot   <= granted_r;
      params_changed <= changed_r;
      scan_window    <= active_window;
      scan_interval  <= active_interval;
    end
  end

`ifndef SYNTH
  // Scanning is on exactly when the stored duty is nonzero
  a_duty_matches_interval: assert property (@(posedge clk) disable iff (rst)
    ((active_interval == '0) == (active_duty == '0)))
    else $error("active duty and active interval disagree on scanning off");

  // The divider finishes only while the sequencer waits for it
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == S_DIV))
    else $error("divider finished outside the divide step");

  // An input beat starts the check step and closes the input
  a_beat_starts_check: assert property (@(posedge clk) disable iff (rst)
    in_beat |=> (state == S_CHECK) && in_stall)
    else $error("input beat did not start an operation");

  // No divide is in flight when a result is completed
  a_done_div_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |-> !div_stat.busy)
    else $error("divider busy at completion");
`endif

endmodule
